// ===== src/tme_pkg.sv =====
// Shared types and constants for the tape machine executor.
// Holds the opcode and fault codes, the queue entry type and the
// sequential address helper; depends on nothing.
package tme_pkg;

    localparam int TAPE_DEPTH = 4096;
    localparam int PROG_DEPTH = 4096;
    localparam int LOOP_DEPTH = 64;

    localparam int PTR_W   = $clog2(TAPE_DEPTH);
    localparam int SCNT_W  = $clog2(LOOP_DEPTH + 1);
    localparam int SIDX_W  = $clog2(LOOP_DEPTH);
    localparam int ADDR_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int FAULT_W = 3;
    localparam int OP_W    = 3;
    localparam int SUM_W   = ADDR_W + 1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_PLUS  = 3'd0,
        OP_MINUS = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_OPEN  = 3'd4,
        OP_CLOSE = 3'd5,
        OP_OUT   = 3'd6,
        OP_IN    = 3'd7
    } op_t;

    typedef enum logic [FAULT_W-1:0] {
        F_NONE  = 3'd0,
        F_BELOW = 3'd1,
        F_END   = 3'd2,
        F_FULL  = 3'd3,
        F_EMPTY = 3'd4
    } fault_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] instr_addr;
        logic [BYTE_W-1:0] in_byte;
        logic [ADDR_W-1:0] seq_addr;
    } item_t;

    // (addr + 1) modulo the program depth, kept to the 12-bit address field.
    // addr + 1 never reaches twice the program depth, so one subtract is enough.
    function automatic logic [ADDR_W-1:0] next_seq(input logic [ADDR_W-1:0] addr);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, addr} + SUM_W'(1);
        if (32'(sum) >= PROG_DEPTH) begin
            sum = SUM_W'(32'(sum) - PROG_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/tme_front.sv =====
// Front end: accepts instruction transactions, unpacks and classifies them
// and hands queue entries on. Depends on tme_pkg.
module tme_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tme_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                      q_ready,
    input  logic                      clr_busy,
    output logic                      q_push,
    output tme_pkg::item_t            q_item
);

    logic [tme_pkg::ADDR_W-1:0] addr;

    assign addr     = s_tdata[14:3];
    // no intake while the tape is being swept after reset
    assign s_tready = q_ready && !clr_busy;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item.op         = tme_pkg::op_t'(s_tdata[2:0]);
        q_item.instr_addr = addr;
        q_item.in_byte    = s_tdata[22:15];
        q_item.seq_addr   = tme_pkg::next_seq(addr);
    end

endmodule

// ===== src/tme_queue.sv =====
// Two-entry queue between the front end and the execute stage.
// Depends on tme_pkg for the entry type.
module tme_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tme_pkg::item_t push_item,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output tme_pkg::item_t head
);

    tme_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign ready = (count_reg != 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/tme_back.sv =====
// Execute stage: tape memory, cell pointer, loop stack, skip depth and
// fault latch, plus the result register. Depends on tme_pkg.
module tme_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  tme_pkg::item_t                q_head,
    output logic                          q_pop,
    output logic                          clr_busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tme_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser
);

    localparam int PTR_W  = tme_pkg::PTR_W;
    localparam int SCNT_W = tme_pkg::SCNT_W;
    localparam int SIDX_W = tme_pkg::SIDX_W;
    localparam int ADDR_W = tme_pkg::ADDR_W;
    localparam int BYTE_W = tme_pkg::BYTE_W;

    logic [BYTE_W-1:0] tape_mem [tme_pkg::TAPE_DEPTH];
    logic [ADDR_W-1:0] stk_mem  [tme_pkg::LOOP_DEPTH];

    logic [BYTE_W-1:0] tape_rdata_reg;
    logic [ADDR_W-1:0] stk_rdata_reg;

    logic              clr_busy_reg;
    logic [PTR_W-1:0]  clr_addr_reg;

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [SCNT_W-1:0] scnt_reg, scnt_next;
    logic [SCNT_W-1:0] skip_reg, skip_next;
    tme_pkg::fault_t   fault_reg, fault_next;
    // current cell lives in cell_reg, or in tape_rdata_reg right after a move
    logic [BYTE_W-1:0] cell_reg, cell_next;
    logic              cell_mem_reg, cell_mem_next;
    // top of stack lives in tos_reg, or in stk_rdata_reg right after a pop
    logic [ADDR_W-1:0] tos_reg, tos_next;
    logic              tos_mem_reg, tos_mem_next;

    logic              m_valid_reg;
    logic [ADDR_W-1:0] res_addr_reg, res_addr;
    logic              res_ov_reg, res_ov;
    logic [BYTE_W-1:0] res_byte_reg, res_byte;
    tme_pkg::fault_t   res_fault_reg, res_fault;

    logic              fire;
    logic [BYTE_W-1:0] cur_byte;
    logic [ADDR_W-1:0] tos;
    tme_pkg::fault_t   f;

    logic              tape_we, tape_re;
    logic [PTR_W-1:0]  tape_waddr, tape_raddr;
    logic [BYTE_W-1:0] tape_wdata;
    logic              stk_we, stk_re;
    logic [SIDX_W-1:0] stk_waddr, stk_raddr;

    assign fire     = q_valid && !clr_busy_reg && (!m_valid_reg || m_tready);
    assign q_pop    = fire;
    assign clr_busy = clr_busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_ov_reg;
    assign m_tdata  = {1'b0, res_fault_reg, res_byte_reg, res_addr_reg};

    assign cur_byte = cell_mem_reg ? tape_rdata_reg : cell_reg;
    assign tos      = tos_mem_reg ? stk_rdata_reg : tos_reg;

    always_comb begin
        ptr_next      = ptr_reg;
        scnt_next     = scnt_reg;
        skip_next     = skip_reg;
        fault_next    = fault_reg;
        cell_next     = cell_reg;
        cell_mem_next = cell_mem_reg;
        tos_next      = tos_reg;
        tos_mem_next  = tos_mem_reg;

        res_addr  = q_head.seq_addr;
        res_ov    = 1'b0;
        res_byte  = '0;
        res_fault = tme_pkg::F_NONE;
        f         = tme_pkg::F_NONE;

        tape_we    = 1'b0;
        tape_waddr = ptr_reg;
        tape_wdata = cur_byte;
        tape_re    = 1'b0;
        tape_raddr = ptr_reg;
        stk_we     = 1'b0;
        stk_waddr  = scnt_reg[SIDX_W-1:0];
        stk_re     = 1'b0;
        stk_raddr  = SIDX_W'(scnt_reg - SCNT_W'(2));

        if (clr_busy_reg) begin
            tape_we    = 1'b1;
            tape_waddr = clr_addr_reg;
            tape_wdata = '0;
        end else if (fire) begin
            if (fault_reg != tme_pkg::F_NONE) begin
                res_addr  = q_head.instr_addr;
                res_fault = fault_reg;
            end else begin
                if (skip_reg != '0) begin
                    case (q_head.op)
                        tme_pkg::OP_OPEN: begin
                            if (skip_reg >= SCNT_W'(tme_pkg::LOOP_DEPTH)) begin
                                f = tme_pkg::F_FULL;
                            end else begin
                                skip_next = skip_reg + SCNT_W'(1);
                            end
                        end
                        tme_pkg::OP_CLOSE: begin
                            skip_next = skip_reg - SCNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    case (q_head.op)
                        tme_pkg::OP_PLUS, tme_pkg::OP_MINUS, tme_pkg::OP_IN: begin
                            if (q_head.op == tme_pkg::OP_PLUS) begin
                                tape_wdata = cur_byte + BYTE_W'(1);
                            end else if (q_head.op == tme_pkg::OP_MINUS) begin
                                tape_wdata = cur_byte - BYTE_W'(1);
                            end else begin
                                tape_wdata = q_head.in_byte;
                            end
                            tape_we       = 1'b1;
                            cell_next     = tape_wdata;
                            cell_mem_next = 1'b0;
                        end
                        tme_pkg::OP_RIGHT: begin
                            if (ptr_reg == PTR_W'(tme_pkg::TAPE_DEPTH - 1)) begin
                                f = tme_pkg::F_END;
                            end else begin
                                ptr_next      = ptr_reg + PTR_W'(1);
                                tape_re       = 1'b1;
                                tape_raddr    = ptr_next;
                                cell_mem_next = 1'b1;
                            end
                        end
                        tme_pkg::OP_LEFT: begin
                            if (ptr_reg == '0) begin
                                f = tme_pkg::F_BELOW;
                            end else begin
                                ptr_next      = ptr_reg - PTR_W'(1);
                                tape_re       = 1'b1;
                                tape_raddr    = ptr_next;
                                cell_mem_next = 1'b1;
                            end
                        end
                        tme_pkg::OP_OPEN: begin
                            if (cur_byte == '0) begin
                                skip_next = SCNT_W'(1);
                            end else if (scnt_reg >= SCNT_W'(tme_pkg::LOOP_DEPTH)) begin
                                f = tme_pkg::F_FULL;
                            end else begin
                                stk_we       = 1'b1;
                                tos_next     = q_head.instr_addr;
                                tos_mem_next = 1'b0;
                                scnt_next    = scnt_reg + SCNT_W'(1);
                            end
                        end
                        tme_pkg::OP_CLOSE: begin
                            if (scnt_reg == '0) begin
                                f = tme_pkg::F_EMPTY;
                            end else if (cur_byte != '0) begin
                                res_addr = tme_pkg::next_seq(tos);
                            end else begin
                                scnt_next = scnt_reg - SCNT_W'(1);
                                // fetch the entry that becomes the new top
                                if (scnt_reg >= SCNT_W'(2)) begin
                                    stk_re       = 1'b1;
                                    tos_mem_next = 1'b1;
                                end
                            end
                        end
                        tme_pkg::OP_OUT: begin
                            res_ov   = 1'b1;
                            res_byte = cur_byte;
                        end
                        default: begin
                        end
                    endcase
                end
                if (f != tme_pkg::F_NONE) begin
                    fault_next = f;
                    res_addr   = q_head.instr_addr;
                    res_ov     = 1'b0;
                    res_byte   = '0;
                end
                res_fault = f;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            ptr_reg       <= '0;
            scnt_reg      <= '0;
            skip_reg      <= '0;
            fault_reg     <= tme_pkg::F_NONE;
            cell_reg      <= '0;
            cell_mem_reg  <= 1'b0;
            tos_mem_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + PTR_W'(1);
                if (clr_addr_reg == PTR_W'(tme_pkg::TAPE_DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            ptr_reg      <= ptr_next;
            scnt_reg     <= scnt_next;
            skip_reg     <= skip_next;
            fault_reg    <= fault_next;
            cell_reg     <= cell_next;
            cell_mem_reg <= cell_mem_next;
            tos_mem_reg  <= tos_mem_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload and top-of-stack copy need no reset
    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        if (fire) begin
            res_addr_reg  <= res_addr;
            res_ov_reg    <= res_ov;
            res_byte_reg  <= res_byte;
            res_fault_reg <= res_fault;
        end
    end

    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (tape_re) begin
            tape_rdata_reg <= tape_mem[tape_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= q_head.instr_addr;
        end
        if (stk_re) begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

endmodule

// ===== src/tape_machine_executor.sv =====
// Execute unit for the eight-command tape language: front end, queue and
// execute stage. Depends on tme_pkg, tme_front, tme_queue and tme_back.
//
// Usage:
//   Input channel s_*: one transaction per instruction, carrying the opcode,
//   its program address and the byte that ',' stores. Result channel m_*: one
//   transaction per instruction with the next fetch address, the output byte
//   and fault code in m_tdata, and m_tuser high when '.' emitted the byte.
//   One instruction per cycle is sustained while m_tready stays high: the
//   current cell and top of stack sit in registers beside the tape and stack
//   memories, so the single read port of each memory is only used on a
//   pointer move or a pop and its data is ready for the next one.
//   After reset the tape is swept to zero, one cell per cycle, across all
//   TAPE_DEPTH (4096) cells; s_tready stays low during the sweep.
//   A stalled receiver holds the result register; the two-entry queue keeps
//   taking transactions until it fills, then s_tready drops.
//   A fault latches: every later instruction returns its own address and the
//   latched code until the next reset.
module tape_machine_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [14:3] instr_addr, [22:15] in_byte, [23] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] next_addr, [19:12] out_byte, [22:20] fault, [23] zero
    output logic [23:0] m_tdata,
    // [0] out_valid
    output logic        m_tuser
);

    logic           q_ready, q_push, q_valid, q_pop, clr_busy;
    tme_pkg::item_t q_item, q_head;

    tme_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_ready),
        .clr_busy (clr_busy),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    tme_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    tme_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clr_busy (clr_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== verif/tape_machine_executor_tb.sv =====
// Self-checking testbench for tape_machine_executor: drives instruction
// streams over the s_ channel and checks each result against a local model.
// Depends on tme_pkg and the tape_machine_executor RTL.
module tape_machine_executor_tb;

    import tme_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int TIMEOUT_CYCLES   = 600_000;
    localparam int RANDOM_ITEMS     = 750;
    localparam int MAX_PROG_STEPS   = 150;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES      = 8;
    localparam int MAX_REPORTS      = 50;

    localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_DEPTH - 1);

    typedef struct packed {
        logic [ADDR_W-1:0] next_addr;
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        fault_t            fault;
    } result_t;

    // ways to end the run in a fault; only one per run since reset never repeats
    typedef enum int {
        TRIP_BELOW,
        TRIP_END,
        TRIP_STACK,
        TRIP_SKIP,
        TRIP_EMPTY
    } trip_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] opcode, [14:3] instr_addr, [22:15] in_byte, [23] zero
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [11:0] next_addr, [19:12] out_byte, [22:20] fault, [23] zero
    logic [23:0] m_tdata;
    // [0] out_valid
    logic        m_tuser;

    // machine state as predicted
    logic [BYTE_W-1:0] tape_img [TAPE_DEPTH];
    logic [PTR_W-1:0]  cell_ptr;
    logic [ADDR_W-1:0] loop_addr [LOOP_DEPTH];
    int                depth_count;
    int                skip_level;
    fault_t            halt_code;

    result_t           pending_results [$];
    logic [ADDR_W-1:0] last_next_addr;
    op_t               prog_mem [PROG_DEPTH];
    op_t               body_pool [8] = '{OP_PLUS, OP_PLUS, OP_MINUS, OP_RIGHT,
                                         OP_LEFT, OP_OUT, OP_IN, OP_MINUS};

    int   exec_count   = 0;
    int   err_count    = 0;
    int   result_index = 0;
    int   burst_left   = 0;
    int   hold_ticket  = 0;
    logic gaps_on      = 1'b1;
    logic rx_stall_en  = 1'b1;

    tape_machine_executor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [ADDR_W-1:0] addr_after(input logic [ADDR_W-1:0] a);
        return ADDR_W'((32'(a) + 1) % PROG_DEPTH);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    // Advances the predicted machine by one instruction.
    function automatic result_t execute_instr(input op_t op, input logic [ADDR_W-1:0] addr,
                                              input logic [BYTE_W-1:0] data);
        result_t           r;
        fault_t            f;
        logic [BYTE_W-1:0] cur_byte;
        r.next_addr = addr_after(addr);
        r.out_valid = 1'b0;
        r.out_byte  = '0;
        r.fault     = F_NONE;
        f           = F_NONE;
        cur_byte    = tape_img[cell_ptr];
        if (halt_code != F_NONE) begin
            r.next_addr = addr;
            r.fault     = halt_code;
            return r;
        end
        if (skip_level != 0) begin
            // skipping to the matching close: only brackets count
            if (op == OP_OPEN) begin
                if (skip_level >= LOOP_DEPTH) begin
                    f = F_FULL;
                end else begin
                    skip_level++;
                end
            end else if (op == OP_CLOSE) begin
                skip_level--;
            end
        end else begin
            case (op)
                OP_PLUS:  tape_img[cell_ptr] = cur_byte + 1'b1;
                OP_MINUS: tape_img[cell_ptr] = cur_byte - 1'b1;
                OP_RIGHT: begin
                    if (cell_ptr == LAST_CELL) begin
                        f = F_END;
                    end else begin
                        cell_ptr = cell_ptr + 1'b1;
                    end
                end
                OP_LEFT: begin
                    if (cell_ptr == '0) begin
                        f = F_BELOW;
                    end else begin
                        cell_ptr = cell_ptr - 1'b1;
                    end
                end
                OP_OPEN: begin
                    if (cur_byte == '0) begin
                        skip_level = 1;
                    end else if (depth_count >= LOOP_DEPTH) begin
                        f = F_FULL;
                    end else begin
                        loop_addr[depth_count] = addr;
                        depth_count++;
                    end
                end
                OP_CLOSE: begin
                    if (depth_count == 0) begin
                        f = F_EMPTY;
                    end else if (cur_byte != '0) begin
                        r.next_addr = addr_after(loop_addr[depth_count - 1]);
                    end else begin
                        depth_count--;
                    end
                end
                OP_OUT: begin
                    r.out_valid = 1'b1;
                    r.out_byte  = cur_byte;
                end
                default: tape_img[cell_ptr] = data;
            endcase
        end
        if (f != F_NONE) begin
            halt_code   = f;
            r.next_addr = addr;
            r.out_valid = 1'b0;
            r.out_byte  = '0;
        end
        r.fault = f;
        return r;
    endfunction

    // Swaps an opcode that would fault in the present state for a harmless one.
    function automatic op_t make_safe(input op_t op);
        if (skip_level != 0) begin
            if (op == OP_OPEN && skip_level >= LOOP_DEPTH) begin
                return OP_CLOSE;
            end
            return op;
        end
        case (op)
            OP_RIGHT: if (cell_ptr == LAST_CELL) return OP_LEFT;
            OP_LEFT:  if (cell_ptr == '0) return OP_RIGHT;
            OP_OPEN:  if (tape_img[cell_ptr] != '0 && depth_count >= LOOP_DEPTH) return OP_PLUS;
            OP_CLOSE: if (depth_count == 0) return OP_PLUS;
            default: ;
        endcase
        return op;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_index, what, got, want);
        end
    endtask

    // One instruction transaction; returns once accepted and predicted.
    task automatic send_instr(input op_t op, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data);
        int      gap;
        result_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, data, addr, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (skip_level == 0 || op == OP_OPEN || op == OP_CLOSE) begin
            exec_count++;
        end
        r              = execute_instr(op, addr, data);
        last_next_addr = r.next_addr;
        pending_results = {pending_results, r};
    endtask

    task automatic send_noise();
        send_instr(make_safe(op_t'($urandom_range(0, 7))), rand_addr(), rand_byte());
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Closes open skips, then pops every stack entry with a zeroed cell.
    task automatic unwind_loops();
        while (skip_level != 0) send_instr(OP_CLOSE, rand_addr(), rand_byte());
        while (depth_count != 0) begin
            send_instr(OP_IN, rand_addr(), '0);
            send_instr(OP_CLOSE, rand_addr(), rand_byte());
        end
    endtask

    // Builds a small bracket-balanced program and follows its control flow.
    task automatic run_program();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] pc;
        logic [BYTE_W-1:0] data;
        int                len;
        int                open_n;
        int                steps;
        int                pick;
        op_t               op;
        base   = rand_addr();
        len    = $urandom_range(6, 40);
        open_n = 0;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (open_n >= len - i) begin
                op = OP_CLOSE;
            end else if (pick < 15 && open_n + 2 <= len - i && open_n < 8) begin
                op = OP_OPEN;
            end else if (pick < 30 && open_n > 0) begin
                op = OP_CLOSE;
            end else begin
                op = body_pool[$urandom_range(0, 7)];
            end
            if (op == OP_OPEN) begin
                open_n++;
            end else if (op == OP_CLOSE) begin
                open_n--;
            end
            prog_mem[ADDR_W'(base + i)] = op;
        end
        pc    = base;
        steps = 0;
        while (pc != ADDR_W'(base + len) && steps < MAX_PROG_STEPS) begin
            // zeros often, so loops terminate
            data = ($urandom_range(0, 3) == 0) ? BYTE_W'(0) : rand_byte();
            send_instr(make_safe(prog_mem[pc]), pc, data);
            pc = last_next_addr;
            steps++;
        end
    endtask

    task automatic test_basic_ops();
        send_instr(OP_IN,    12'd0,    8'd255);
        send_instr(OP_OUT,   12'd1,    rand_byte());
        send_instr(OP_PLUS,  12'd2,    rand_byte());
        send_instr(OP_OUT,   12'd3,    rand_byte());
        send_instr(OP_MINUS, 12'd4,    rand_byte());
        send_instr(OP_OUT,   12'd4095, rand_byte());
        send_instr(OP_RIGHT, 12'd0,    rand_byte());
        send_instr(OP_OUT,   12'd1,    rand_byte());
        send_instr(OP_LEFT,  12'd2,    rand_byte());
        send_instr(OP_OUT,   12'd3,    rand_byte());
        send_instr(OP_IN,    12'd4095, 8'd0);
        // open on a zero cell: skip with nesting
        send_instr(OP_OPEN,  12'd5,    rand_byte());
        send_instr(OP_PLUS,  12'd6,    rand_byte());
        send_instr(OP_OPEN,  12'd7,    rand_byte());
        send_instr(OP_OUT,   12'd8,    rand_byte());
        send_instr(OP_CLOSE, 12'd9,    rand_byte());
        send_instr(OP_CLOSE, 12'd10,   rand_byte());
        // loop back from an open at the top address wraps to zero
        send_instr(OP_IN,    12'd11,   8'd3);
        send_instr(OP_OPEN,  12'd4095, rand_byte());
        send_instr(OP_MINUS, 12'd0,    rand_byte());
        send_instr(OP_CLOSE, 12'd1,    rand_byte());
        send_instr(OP_IN,    12'd0,    8'd0);
        send_instr(OP_CLOSE, 12'd1,    rand_byte());
        send_instr(OP_OUT,   12'd2,    rand_byte());
    endtask

    task automatic test_loop_stack();
        send_instr(OP_IN, rand_addr(), 8'd1);
        repeat (LOOP_DEPTH) send_instr(OP_OPEN, rand_addr(), rand_byte());
        repeat (LOOP_DEPTH) begin
            send_instr(OP_IN, rand_addr(), BYTE_W'($urandom_range(1, 255)));
            send_instr(OP_CLOSE, rand_addr(), rand_byte());
            send_instr(OP_IN, rand_addr(), '0);
            send_instr(OP_CLOSE, rand_addr(), rand_byte());
        end
    endtask

    task automatic test_skip_nesting();
        send_instr(OP_IN, rand_addr(), '0);
        repeat (LOOP_DEPTH) send_instr(OP_OPEN, rand_addr(), rand_byte());
        repeat (8) send_instr(op_t'($urandom_range(0, 3)), rand_addr(), rand_byte());
        repeat (LOOP_DEPTH) send_instr(OP_CLOSE, rand_addr(), rand_byte());
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_ticket++;
        repeat (40) send_noise();
        drain_results();
        gaps_on = 1'b1;
        repeat (20) send_noise();
        drain_results();
    endtask

    task automatic test_random_programs();
        int start;
        start = exec_count;
        while (exec_count - start < RANDOM_ITEMS) begin
            gaps_on     = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8)) send_noise();
            end else begin
                unwind_loops();
                run_program();
            end
        end
        gaps_on     = 1'b1;
        rx_stall_en = 1'b1;
        unwind_loops();
    endtask

    // Walks the pointer across the whole tape and back.
    task automatic test_tape_walk();
        unwind_loops();
        while (cell_ptr != LAST_CELL) begin
            if ($urandom_range(0, 63) == 0) begin
                send_instr(OP_IN, rand_addr(), rand_byte());
            end
            send_instr(OP_RIGHT, rand_addr(), rand_byte());
        end
        send_instr(OP_PLUS, rand_addr(), rand_byte());
        send_instr(OP_OUT, rand_addr(), rand_byte());
        while (cell_ptr != '0) begin
            if ($urandom_range(0, 31) == 0) begin
                send_instr(OP_OUT, rand_addr(), rand_byte());
            end
            send_instr(OP_LEFT, rand_addr(), rand_byte());
        end
    endtask

    task automatic test_fault_halt();
        trip_t kind;
        kind = trip_t'($urandom_range(0, 4));
        unwind_loops();
        case (kind)
            TRIP_BELOW: begin
                while (cell_ptr != '0) send_instr(OP_LEFT, rand_addr(), rand_byte());
                send_instr(OP_LEFT, rand_addr(), rand_byte());
            end
            TRIP_END: begin
                while (cell_ptr != LAST_CELL) send_instr(OP_RIGHT, rand_addr(), rand_byte());
                send_instr(OP_RIGHT, rand_addr(), rand_byte());
            end
            TRIP_STACK: begin
                send_instr(OP_IN, rand_addr(), 8'd1);
                repeat (LOOP_DEPTH + 1) send_instr(OP_OPEN, rand_addr(), rand_byte());
            end
            TRIP_SKIP: begin
                send_instr(OP_IN, rand_addr(), '0);
                repeat (LOOP_DEPTH + 1) send_instr(OP_OPEN, rand_addr(), rand_byte());
            end
            default: send_instr(OP_CLOSE, rand_addr(), rand_byte());
        endcase
        // halted: every later transaction echoes its address and the latched code
        repeat (16) send_instr(op_t'($urandom_range(0, 7)), rand_addr(), rand_byte());
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[11:0] != want.next_addr) begin
                    report_mismatch("next_addr", m_tdata[11:0], want.next_addr);
                end
                if (m_tuser != want.out_valid) begin
                    report_mismatch("out_valid", m_tuser, want.out_valid);
                end
                if (m_tdata[19:12] != want.out_byte) begin
                    report_mismatch("out_byte", m_tdata[19:12], want.out_byte);
                end
                if (m_tdata[22:20] != want.fault) begin
                    report_mismatch("fault", m_tdata[22:20], want.fault);
                end
            end
            result_index++;
        end
    end

    // Receiver: short ready runs and stalls, plus a long hold on request.
    initial begin : rx_side
        int stall_left;
        int run_left;
        int hold_done;
        stall_left = 0;
        run_left   = 0;
        hold_done  = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_done != hold_ticket) begin
                hold_done  = hold_ticket;
                run_left   = 0;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (run_left > 0) begin
                run_left--;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                run_left   = $urandom_range(0, 11);
                stall_left = rx_stall_en ? $urandom_range(0, 4) : 0;
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("tb: failure");
        $finish;
    end

    initial begin
        foreach (tape_img[i]) tape_img[i] = '0;
        cell_ptr    = '0;
        depth_count = 0;
        skip_level  = 0;
        halt_code   = F_NONE;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_loop_stack();
        test_skip_nesting();
        test_backpressure();
        test_random_programs();
        test_tape_walk();
        test_fault_halt();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
